/* hw/rtl/sfps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfps_pkg;

  // width of the result index port, fixed by the interface
  localparam int OUT_INDEX_W = 16;

  // width of the pattern length register
  localparam int LEN_W = 4;

  // width of the packed pattern register
  localparam int PATTERN_W = 64;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_index_t;

  // classified text item passed from front to back
  typedef struct packed {
    logic [7:0] text_byte;
    logic       present;
    logic       last;
  } text_op_t;

  // one search result
  typedef struct packed {
    logic                   found;
    logic [OUT_INDEX_W-1:0] first_index;
    logic                   starts;
    logic                   ends;
    logic                   overflow;
  } search_result_t;

endpackage

`default_nettype wire

/* hw/rtl/sfps_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == COUNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sfps_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfps_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        text_byte,
  input  wire logic              byte_present,
  input  wire logic              last_byte,
  output logic                   op_valid,
  output sfps_pkg::text_op_t     op,
  input  wire logic              op_ready
);

  sfps_pkg::text_op_t in_op;
  logic               keep;
  logic               op_empty;

  // items with neither a byte nor an end mark have no effect: dropped here
  assign in_op.text_byte = text_byte;
  assign in_op.present   = byte_present;
  assign in_op.last      = last_byte;
  assign keep            = push && (byte_present || last_byte);

  sfps_fifo #(
    .WIDTH($bits(sfps_pkg::text_op_t)),
    .DEPTH(2)
  ) u_op_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (keep),
    .wr_data(in_op),
    .full   (full),
    .rd_en  (op_ready),
    .rd_data(op),
    .empty  (op_empty)
  );

  assign op_valid = !op_empty;

endmodule

`default_nettype wire

/* hw/rtl/sfps_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfps_back #(
  parameter int MAX_PATTERN = 8,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [sfps_pkg::PATTERN_W-1:0]        pattern_bytes,
  input  wire logic [sfps_pkg::LEN_W-1:0]            pattern_length,
  input  wire logic                                  op_valid,
  input  wire sfps_pkg::text_op_t                    op,
  output logic                                       op_ready,
  output logic                                       empty,
  input  wire logic                                  pop,
  output sfps_pkg::search_result_t                   result
);

  localparam int WIN_W = 8 * MAX_PATTERN;
  localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

  logic [WIN_W-1:0]                window;
  logic [INDEX_BITS-1:0]           byte_count;
  logic [INDEX_BITS-1:0]           match_index;
  logic                            match_seen;
  logic                            prefix_matched;
  logic                            count_overflowed;

  logic [WIN_W-1:0]                window_next;
  logic [INDEX_BITS-1:0]           byte_count_next;
  logic [INDEX_BITS-1:0]           match_index_next;
  logic                            match_seen_next;
  logic                            prefix_matched_next;
  logic                            count_overflowed_next;

  logic [sfps_pkg::LEN_W-1:0]      eff_len;
  logic [INDEX_BITS-1:0]           len_wide;
  logic                            saturated;
  logic                            win_match;
  logic                            hit;
  logic                            res_full;
  logic                            fire;
  logic                            emit;
  logic [sfps_pkg::OUT_INDEX_W-1:0] index_out;
  sfps_pkg::search_result_t        res_in;

  assign eff_len  = (pattern_length > sfps_pkg::LEN_W'(MAX_PATTERN))
                    ? sfps_pkg::LEN_W'(MAX_PATTERN) : pattern_length;
  assign len_wide = INDEX_BITS'(eff_len);

  assign op_ready = op_valid && !(op.last && res_full);
  assign fire     = op_ready;
  assign emit     = fire && op.last;

  always_comb begin
    window_next           = window;
    byte_count_next       = byte_count;
    match_index_next      = match_index;
    match_seen_next       = match_seen;
    prefix_matched_next   = prefix_matched;
    count_overflowed_next = count_overflowed;
    saturated             = (byte_count == COUNT_MAX);
    if (op.present) begin
      window_next = (window << 8) | WIN_W'(op.text_byte);
      if (saturated) begin
        count_overflowed_next = 1'b1;
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
    end
    // oldest of the last len bytes lines up with pattern byte zero
    win_match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(eff_len)) begin
        if (window_next[8*(int'(eff_len)-1-i) +: 8] != pattern_bytes[8*i +: 8]) begin
          win_match = 1'b0;
        end
      end
    end
    hit = (eff_len != '0) && (byte_count_next >= len_wide) && win_match;
    if (op.present && hit) begin
      if (!match_seen) begin
        match_seen_next  = 1'b1;
        match_index_next = saturated ? COUNT_MAX : byte_count_next - len_wide;
      end
      if (!saturated && (byte_count_next == len_wide)) begin
        prefix_matched_next = 1'b1;
      end
    end
  end

  if (INDEX_BITS > sfps_pkg::OUT_INDEX_W) begin : g_idx_sat
    assign index_out = (|match_index_next[INDEX_BITS-1:sfps_pkg::OUT_INDEX_W])
                       ? '1 : match_index_next[sfps_pkg::OUT_INDEX_W-1:0];
  end else begin : g_idx_ext
    assign index_out = sfps_pkg::OUT_INDEX_W'(match_index_next);
  end

  always_comb begin
    res_in.overflow = count_overflowed_next;
    if (eff_len == '0) begin
      res_in.found       = 1'b1;
      res_in.first_index = '0;
      res_in.starts      = 1'b1;
      res_in.ends        = 1'b1;
    end else begin
      res_in.found       = match_seen_next;
      res_in.first_index = match_seen_next ? index_out : '0;
      res_in.starts      = prefix_matched_next;
      res_in.ends        = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      window      <= window_next;
      match_index <= match_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      match_seen       <= 1'b0;
      prefix_matched   <= 1'b0;
      count_overflowed <= 1'b0;
    end else if (emit) begin
      byte_count       <= '0;
      match_seen       <= 1'b0;
      prefix_matched   <= 1'b0;
      count_overflowed <= 1'b0;
    end else if (fire) begin
      byte_count       <= byte_count_next;
      match_seen       <= match_seen_next;
      prefix_matched   <= prefix_matched_next;
      count_overflowed <= count_overflowed_next;
    end
  end

  sfps_fifo #(
    .WIDTH($bits(sfps_pkg::search_result_t)),
    .DEPTH(2)
  ) u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (emit),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule

`default_nettype wire

/* hw/rtl/substring_find_prefix_suffix.sv */
`timescale 1ns / 1ps
`default_nettype none

// streaming substring search: text bytes enter one per transaction on the push side and
// slide through a window of the last MAX_PATTERN bytes, which is compared in parallel
// against the pattern in pattern_bytes (first byte in the low byte) of pattern_length
// bytes (lengths above MAX_PATTERN are clipped). a transaction with last_byte set closes
// the text and yields one result: found, first_index of the first occurrence (0 if none,
// saturating at 65535), starts_with_pattern, ends_with_pattern and length_overflow, the
// latter set once the byte counter of INDEX_BITS bits has saturated. an empty pattern
// reports found at index 0 with both flags set. byte_present low with last_byte low is
// a no-op; with last_byte high it closes the text without adding a byte. throughput is
// one text byte per clock while the result queue has room; the window compare in the
// back end is combinational. a closing transaction waits in the back end while the
// result queue is full, and its result enters that queue when it is accepted. the
// pattern may only be written while no text is in flight.

module substring_find_prefix_suffix #(
  parameter int MAX_PATTERN = 8,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // text input queue
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [7:0]                         text_byte,
  input  wire logic                               byte_present,
  input  wire logic                               last_byte,
  // result queue
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    found,
  output logic [sfps_pkg::OUT_INDEX_W-1:0]        first_index,
  output logic                                    starts_with_pattern,
  output logic                                    ends_with_pattern,
  output logic                                    length_overflow,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [0:0]                         cfg_index,
  input  wire logic [sfps_pkg::PATTERN_W-1:0]     cfg_data
);

  logic [sfps_pkg::PATTERN_W-1:0] pattern_bytes;
  logic [sfps_pkg::LEN_W-1:0]     pattern_length;

  logic                           op_valid;
  logic                           op_ready;
  sfps_pkg::text_op_t             op;
  sfps_pkg::search_result_t       result;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfps_pkg::reg_index_t'(cfg_index))
        sfps_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        sfps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[sfps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: takes transactions, drops no-op items, queues the rest
  sfps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .byte_present(byte_present),
    .last_byte   (last_byte),
    .op_valid    (op_valid),
    .op          (op),
    .op_ready    (op_ready)
  );

  // back end: window, counters and result queue
  sfps_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pattern_bytes (pattern_bytes),
    .pattern_length(pattern_length),
    .op_valid      (op_valid),
    .op            (op),
    .op_ready      (op_ready),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

  assign found               = result.found;
  assign first_index         = result.first_index;
  assign starts_with_pattern = result.starts;
  assign ends_with_pattern   = result.ends;
  assign length_overflow     = result.overflow;

  // back end never consumes an op the front has not queued
  a_op_handoff: assert property (@(posedge clk) disable iff (rst)
    op_ready |-> op_valid)
    else $error("back end consumed from an empty op queue");

  // a miss always reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (first_index == '0))
    else $error("nonzero index on a miss");

  // prefix or suffix hit implies the pattern was found
  a_flags_imply_found: assert property (@(posedge clk) disable iff (rst)
    (!empty && (starts_with_pattern || ends_with_pattern)) |-> found)
    else $error("prefix or suffix flag without found");

endmodule

`default_nettype wire

/* test/substring_find_prefix_suffix_tb.sv */
`timescale 1ns / 1ps

module substring_find_prefix_suffix_tb;

  localparam int MAX_PATTERN = 8;
  localparam int INDEX_BITS = 16;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int RANDOM_ITEMS = 700;
  // idle cycles after the last push before a register write is offered
  localparam int SETTLE_CYCLES = 8;
  // no idling while this few operations are left
  localparam int TAIL_OPS = 120;
  // cycles with no transaction on any port before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic {
    OP_TEXT,
    OP_REG_WRITE
  } op_kind_t;

  typedef struct {
    op_kind_t             kind;
    logic [7:0]           text_byte;
    logic                 present;
    logic                 last;
    sfps_pkg::reg_index_t idx;
    logic [63:0]          data;
  } bus_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       text_byte = 8'h00;
  logic                             byte_present = 1'b0;
  logic                             last_byte = 1'b0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic                             found;
  logic [sfps_pkg::OUT_INDEX_W-1:0] first_index;
  logic                             starts_with_pattern;
  logic                             ends_with_pattern;
  logic                             length_overflow;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [0:0]                       cfg_index = 1'b0;
  logic [sfps_pkg::PATTERN_W-1:0]   cfg_data = '0;

  always #5 clk = ~clk;

  substring_find_prefix_suffix #(
    .MAX_PATTERN(MAX_PATTERN),
    .INDEX_BITS (INDEX_BITS)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .text_byte          (text_byte),
    .byte_present       (byte_present),
    .last_byte          (last_byte),
    .empty              (empty),
    .pop                (pop),
    .found              (found),
    .first_index        (first_index),
    .starts_with_pattern(starts_with_pattern),
    .ends_with_pattern  (ends_with_pattern),
    .length_overflow    (length_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // operations still to be driven, and search results still to come out
  bus_op_t                  bus_ops[$];
  sfps_pkg::search_result_t search_results_due[$];

  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned real_items = 0;
  bit          tail_mode = 1'b0;

  // ---------------------------------------------------------------------------
  // local copy of the search state, advanced once per accepted transaction
  // ---------------------------------------------------------------------------
  logic [63:0] pat_reg;
  logic [3:0]  len_reg;
  logic [7:0]  win [MAX_PATTERN];
  logic [15:0] byte_cnt;
  logic [15:0] first_at;
  bit          seen;
  bit          at_start;
  bit          sat_flag;

  // win[0] holds the newest byte, so the oldest of the last n bytes is win[n-1]
  function automatic bit window_hit(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (win[n-1-i] != pat_reg[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_search();
    int i;
    for (i = 0; i < MAX_PATTERN; i++) win[i] = 8'h00;
    byte_cnt = '0;
    first_at = '0;
    seen = 1'b0;
    at_start = 1'b0;
    sat_flag = 1'b0;
  endtask

  task automatic apply_reg_write(bus_op_t op);
    if (op.idx == sfps_pkg::REG_PATTERN_BYTES) pat_reg = op.data;
    else len_reg = op.data[3:0];
  endtask

  task automatic search_step(bus_op_t op);
    int n;
    int k;
    bit sat_now;
    sfps_pkg::search_result_t r;
    // lengths above the window size are clipped
    n = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
    sat_now = 1'b0;
    if (op.present) begin
      for (k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = op.text_byte;
      // the counter sticks at its top value and flags the overflow
      if (byte_cnt == COUNT_MAX) begin
        sat_flag = 1'b1;
        sat_now = 1'b1;
      end else begin
        byte_cnt = byte_cnt + 16'd1;
      end
      if (n > 0 && int'(byte_cnt) >= n && window_hit(n)) begin
        if (!seen) begin
          seen = 1'b1;
          first_at = sat_now ? COUNT_MAX : 16'(int'(byte_cnt) - n);
        end
        if (!sat_now && int'(byte_cnt) == n) at_start = 1'b1;
      end
    end
    if (op.last) begin
      r.overflow = sat_flag;
      if (n == 0) begin
        // empty pattern matches at the very start
        r.found = 1'b1;
        r.first_index = '0;
        r.starts = 1'b1;
        r.ends = 1'b1;
      end else begin
        r.found = seen;
        r.first_index = seen ? first_at : '0;
        r.starts = at_start;
        r.ends = (int'(byte_cnt) >= n) && window_hit(n);
      end
      search_results_due.push_back(r);
      clear_search();
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: push side and register write channel
  // ---------------------------------------------------------------------------
  int unsigned push_gap;
  int unsigned push_odds;
  int unsigned since_push;
  bit          next_push;
  bit          next_cfg;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
      push_gap = 0;
      push_odds = 4;
      since_push = 0;
      pat_reg = '0;
      len_reg = '0;
      clear_search();
    end else begin
      next_push = 1'b0;
      next_cfg = 1'b0;
      if (push && !full) begin
        search_step(bus_ops.pop_front());
        since_push = 0;
      end else begin
        if (since_push < SETTLE_CYCLES) since_push++;
        // an offered byte stays up until it is taken
        if (push) next_push = 1'b1;
      end
      if (cfg_valid && cfg_ready) apply_reg_write(bus_ops.pop_front());
      else if (cfg_valid) next_cfg = 1'b1;

      tail_mode = (bus_ops.size() <= TAIL_OPS);
      // a burst still running when the tail starts is cut short
      if (tail_mode) push_gap = 0;
      // change the idling density now and then, zero gives calm stretches
      if ($urandom_range(63) == 0) begin
        case ($urandom_range(2))
          0: push_odds = 0;
          1: push_odds = 3;
          default: push_odds = 12;
        endcase
      end

      if (!next_push && !next_cfg && bus_ops.size() != 0) begin
        if (push_gap != 0) begin
          push_gap--;
        end else if (!tail_mode && push_odds != 0 && $urandom_range(push_odds - 1) == 0) begin
          // start a burst of idle cycles, this one included; push_gap counts the rest
          push_gap = $urandom_range(8, 0);
        end else if (bus_ops[0].kind == OP_TEXT) begin
          next_push = 1'b1;
          text_byte <= bus_ops[0].text_byte;
          byte_present <= bus_ops[0].present;
          last_byte <= bus_ops[0].last;
        end else if (search_results_due.size() == 0 && since_push >= SETTLE_CYCLES) begin
          // registers only change with the block idle
          next_cfg = 1'b1;
          cfg_index <= bus_ops[0].idx;
          cfg_data <= bus_ops[0].data;
        end
      end
      push <= next_push;
      cfg_valid <= next_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: pop side, compares against the oldest expected result
  // ---------------------------------------------------------------------------
  int unsigned              pop_gap;
  int unsigned              pop_odds;
  sfps_pkg::search_result_t want;

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_gap = 0;
      pop_odds = 4;
    end else begin
      if (pop && !empty) begin
        if (search_results_due.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual index %0d",
                   $time, first_index);
          errors++;
        end else begin
          want = search_results_due.pop_front();
          check_field("found", 16'(want.found), 16'(found));
          check_field("first_index", want.first_index, first_index);
          check_field("starts_with_pattern", 16'(want.starts), 16'(starts_with_pattern));
          check_field("ends_with_pattern", 16'(want.ends), 16'(ends_with_pattern));
          check_field("length_overflow", 16'(want.overflow), 16'(length_overflow));
        end
      end
      if ($urandom_range(63) == 0) begin
        case ($urandom_range(2))
          0: pop_odds = 0;
          1: pop_odds = 3;
          default: pop_odds = 12;
        endcase
      end
      if (tail_mode) pop_gap = 0;
      if (pop_gap != 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!tail_mode && pop_odds != 0 && $urandom_range(pop_odds - 1) == 0) begin
        pop_gap = $urandom_range(8, 0);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: cycles since the last transaction on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  logic [7:0]  text_buf[$];
  logic [63:0] stim_pat;
  logic [3:0]  stim_len;
  logic [7:0]  alphabet[3];

  task automatic queue_item(logic [7:0] b, bit present, bit last);
    bus_op_t op;
    op.kind = OP_TEXT;
    op.text_byte = b;
    op.present = present;
    op.last = last;
    op.idx = sfps_pkg::REG_PATTERN_BYTES;
    op.data = '0;
    bus_ops.push_back(op);
    // bytes that are neither present nor closing do nothing
    if (present || last) real_items++;
  endtask

  task automatic queue_reg_write(sfps_pkg::reg_index_t idx, logic [63:0] data);
    bus_op_t op;
    op.kind = OP_REG_WRITE;
    op.text_byte = 8'h00;
    op.present = 1'b0;
    op.last = 1'b0;
    op.idx = idx;
    op.data = data;
    bus_ops.push_back(op);
  endtask

  // sends text_buf as one text, closed either on its final byte or by an
  // absent closing transaction; noisy scatters absent no-op transactions
  task automatic queue_text(bit close_absent, bit noisy);
    int i;
    for (i = 0; i < text_buf.size(); i++) begin
      if (noisy && $urandom_range(9) == 0) queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
      queue_item(text_buf[i], 1'b1, (i == text_buf.size() - 1) && !close_absent);
    end
    if (close_absent || text_buf.size() == 0)
      queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic append_pattern();
    int j;
    int n;
    n = (stim_len > MAX_PATTERN) ? MAX_PATTERN : int'(stim_len);
    for (j = 0; j < n; j++) text_buf.push_back(stim_pat[8*j +: 8]);
  endtask

  task automatic set_pattern(logic [63:0] bytes_val, logic [63:0] len_val);
    stim_pat = bytes_val;
    stim_len = len_val[3:0];
    if ($urandom_range(1) == 0) begin
      queue_reg_write(sfps_pkg::REG_PATTERN_BYTES, bytes_val);
      queue_reg_write(sfps_pkg::REG_PATTERN_LENGTH, len_val);
    end else begin
      queue_reg_write(sfps_pkg::REG_PATTERN_LENGTH, len_val);
      queue_reg_write(sfps_pkg::REG_PATTERN_BYTES, bytes_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  bit timed_out = 1'b0;

  initial begin
    int k;
    int sel;
    int target;
    int n_texts;
    logic [63:0] len_word;
    logic [63:0] pat_word;

    // directed: reset registers give the empty pattern
    stim_pat = '0;
    stim_len = '0;
    text_buf = '{8'h71};
    queue_text(1'b0, 1'b0);
    text_buf.delete();
    queue_text(1'b1, 1'b0);

    // three byte pattern, junk in the unused bytes and length bits
    set_pattern(64'hA5A5_5A5A_0063_6261, 64'hFFFF_FFFF_FFFF_FFF3);
    text_buf = '{8'h61, 8'h62, 8'h63};
    queue_text(1'b0, 1'b0);
    text_buf = '{8'h7A, 8'h61, 8'h62, 8'h63};
    // no-op transaction in the middle of the text
    queue_item(text_buf[0], 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(text_buf[1], 1'b1, 1'b0);
    queue_item(text_buf[2], 1'b1, 1'b0);
    queue_item(text_buf[3], 1'b1, 1'b1);
    // empty text, then a text shorter than the pattern closed by an absent byte
    text_buf.delete();
    queue_text(1'b1, 1'b0);
    text_buf = '{8'h61, 8'h62};
    queue_text(1'b1, 1'b0);

    // over-long length is clipped to the window, zero bytes compared as bytes
    set_pattern(64'h00FF_00FF_00FF_00FF, 64'h0000_0000_0000_000F);
    text_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    queue_text(1'b0, 1'b0);

    // random phases: a new pattern drawn from a small alphabet, then a few
    // texts built from the same alphabet with pattern copies spliced in
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(9) == 0) alphabet[k] = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
        else alphabet[k] = 8'($urandom_range(255));
      end
      for (k = 0; k < 8; k++) begin
        if ($urandom_range(5) == 0) pat_word[8*k +: 8] = 8'($urandom_range(255));
        else pat_word[8*k +: 8] = alphabet[$urandom_range(2)];
      end
      sel = $urandom_range(9);
      len_word = {$urandom(), $urandom()};
      if (sel == 0) len_word[3:0] = 4'd0;
      else if (sel == 1) len_word[3:0] = 4'd8;
      else if (sel == 2) len_word[3:0] = 4'($urandom_range(15, 9));
      else len_word[3:0] = 4'($urandom_range(8, 1));
      set_pattern(pat_word, len_word);

      n_texts = $urandom_range(6, 1);
      for (k = 0; k < n_texts; k++) begin
        text_buf.delete();
        target = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(16);
        if ($urandom_range(2) == 0) append_pattern();
        while (text_buf.size() < target) begin
          if ($urandom_range(4) == 0) append_pattern();
          else if ($urandom_range(7) == 0) text_buf.push_back(8'($urandom_range(255)));
          else text_buf.push_back(alphabet[$urandom_range(2)]);
        end
        if ($urandom_range(2) == 0) append_pattern();
        queue_text($urandom_range(3) == 0, $urandom_range(2) == 0);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so queue updates have all settled
    while (!timed_out && !(bus_ops.size() == 0 && search_results_due.size() == 0)) begin
      @(negedge clk);
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
    // let any stray result surface before the verdict
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);

    if (!timed_out && errors == 0)
      $display("substring_find_prefix_suffix_tb OK");
    else
      $display("substring_find_prefix_suffix_tb NOT OK");
    $finish;
  end

endmodule
